### hdl/qdf_pkg.sv
// Package for the quadratic drag force core: constants, types and helpers.
package qdf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Root unit width: 68-bit radicand, 34-bit root
  localparam int SQ_W   = 68;
  localparam int ROOT_W = 34;

  // 0.6125 in Qx.F, ties away from zero
  function automatic logic [63:0] half_rho_q(input int frac);
    logic [63:0] num;
    num = (64'd49 << frac) + 64'd40;
    return num / 64'd80;
  endfunction

  typedef struct packed {
    logic        sat;
    logic        zero;
  } qdf_flags_t;

endpackage

### hdl/qdf_mul64.sv
// Pipelined 64x64 multiply, shift right by FRAC_BITS, saturate to 2^64-1.
module qdf_mul64 import qdf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p,
  output logic        sat
);

  logic [63:0] p0_r, p1_r, p2_r, p3_r;
  logic [63:0] mid;
  logic [63:0] lo;
  logic [63:0] hi;

  // Form four 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= a[31:0]  * b[31:0];
      p1_r <= a[31:0]  * b[63:32];
      p2_r <= a[63:32] * b[31:0];
      p3_r <= a[63:32] * b[63:32];
    end
  end

  // Combine and saturate
  always_comb begin
    mid = {32'd0, p0_r[63:32]} + {32'd0, p1_r[31:0]} + {32'd0, p2_r[31:0]};
    lo  = {mid[31:0], p0_r[31:0]};
    hi  = p3_r + {32'd0, p1_r[63:32]} + {32'd0, p2_r[63:32]} + {32'd0, mid[63:32]};
    sat = (hi >> FRAC_BITS) != 64'd0;
    p   = sat ? '1 : ((lo >> FRAC_BITS) | (hi << (64 - FRAC_BITS)));
  end

endmodule

### hdl/quadratic_drag_force_core.sv
// Top level of the quadratic drag force core: pipelined drag datapath.
//
// Use: one body per request on the in_ channel (tdata holds twelve Q16.16
// words, wind_x in the lowest bits), one force result per request on the
// out_ channel (force_x/y/z Q48.16, then force_is_zero, then saturated).
// Throughput: one request per cycle, back to back, while out_tready does not stall.
// Pipeline, from the accepting edge to out_tvalid: two input stages, the
// 34-step pipelined square root, four chained pipelined 64x64 multiplies,
// each with its result registered once more, the per-axis multiply and a
// final output register.
// All stages advance together when the output register is free or taken;
// a stall at out_tready freezes the whole pipe and in_tready drops, so no
// request is lost or repeated.
// Reset (rst_n low, synchronous) clears every valid bit; data registers
// keep stale values that are never shown.
module quadratic_drag_force_core import qdf_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // wind_x, wind_y, wind_z, body_vx, body_vy, body_vz, extent_x, extent_y,
  // extent_z, exposed_area, drag_coefficient, force_scale
  input  logic [383:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // force_x, force_y, force_z, force_is_zero, saturated, 6 zero bits
  output logic [199:0] out_tdata
);

  localparam int NSQ   = ROOT_W;          // root stages
  localparam int NMUL  = 5;               // multiply stages
  localparam int DEPTH = 2 + NSQ + 2 * NMUL;
  localparam logic [63:0] KQ = half_rho_q(FRAC_BITS);

  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic [DEPTH-1:0] vld_r;

  // Advance the valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // Stage 0: relative velocity, area, gates
  logic signed [32:0] r0_r [3];
  logic [63:0] ap_r [3];
  logic [31:0] ea_r, cd_r, sc_r;
  logic        eapos_r;
  logic [32:0] ex [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ex[i] = $signed(in_tdata[192+32*i +: 32]) > 0 ?
              {in_tdata[192+32*i +: 32], 1'b0} : 33'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r0_r[i] <= $signed({in_tdata[32*i+31], in_tdata[32*i +: 32]})
                 - $signed({in_tdata[96+32*i+31], in_tdata[96+32*i +: 32]});
      end
      ap_r[0] <= {31'd0, ex[0]} * {31'd0, ex[1]};
      ap_r[1] <= {31'd0, ex[0]} * {31'd0, ex[2]};
      ap_r[2] <= {31'd0, ex[1]} * {31'd0, ex[2]};
      ea_r    <= in_tdata[288 +: 32];
      cd_r    <= in_tdata[320 +: 32];
      sc_r    <= in_tdata[352 +: 32];
      eapos_r <= $signed(in_tdata[288 +: 32]) > 0;
    end
  end

  // Stage 1: squares summed, area chosen
  logic [32:0] mag0 [3];
  logic [SQ_W-1:0] sq1_r;
  logic [63:0] area1_r, amax;
  logic [32:0] mag1_r [3];
  logic [2:0]  neg1_r;
  logic        gate1_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag0[i] = r0_r[i][32] ? 33'(-r0_r[i]) : 33'(r0_r[i]);
    end
    amax = ap_r[0];
    if (ap_r[1] > amax) amax = ap_r[1];
    if (ap_r[2] > amax) amax = ap_r[2];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1_r <= 68'({2'd0, mag0[0]} * {2'd0, mag0[0]})
             + 68'({2'd0, mag0[1]} * {2'd0, mag0[1]})
             + 68'({2'd0, mag0[2]} * {2'd0, mag0[2]});
      area1_r <= eapos_r ? {32'd0, ea_r} : (amax >> FRAC_BITS);
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= mag0[i];
        neg1_r[i] <= r0_r[i][32];
      end
      gate1_r <= $signed(cd_r) > 0 && $signed(sc_r) > 0;
    end
  end

  // cd/sc in stage 0 regs change with each advance; capture into stage 1 copies
  logic [31:0] cd1_r, sc1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      cd1_r <= cd_r;
      sc1_r <= sc_r;
    end
  end

  // Square root pipeline: one result bit per stage
  logic [SQ_W-1:0]   rad_r  [NSQ+1];
  logic [ROOT_W-1:0] root_r [NSQ+1];
  logic [ROOT_W+1:0] rem_r  [NSQ+1];
  logic [63:0]       area_p [NSQ+1];
  logic [32:0]       mag_p  [NSQ+1][3];
  logic [2:0]        neg_p  [NSQ+1];
  logic              gate_p [NSQ+1];
  logic [31:0]       cd_p   [NSQ+1];
  logic [31:0]       sc_p   [NSQ+1];

  always_comb begin
    rad_r[0]  = sq1_r;
    root_r[0] = '0;
    rem_r[0]  = '0;
    area_p[0] = area1_r;
    mag_p[0]  = mag1_r;
    neg_p[0]  = neg1_r;
    gate_p[0] = gate1_r;
    cd_p[0]   = cd1_r;
    sc_p[0]   = sc1_r;
  end

  for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
    logic [ROOT_W+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {rem_r[g][ROOT_W-1:0], rad_r[g][SQ_W-1 -: 2]};
      trial  = {root_r[g], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rad_r[g+1]  <= rad_r[g] << 2;
        if (rem_sh >= trial) begin
          rem_r[g+1]  <= rem_sh - trial;
          root_r[g+1] <= {root_r[g][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[g+1]  <= rem_sh;
          root_r[g+1] <= {root_r[g][ROOT_W-2:0], 1'b0};
        end
        area_p[g+1] <= area_p[g];
        mag_p[g+1]  <= mag_p[g];
        neg_p[g+1]  <= neg_p[g];
        gate_p[g+1] <= gate_p[g];
        cd_p[g+1]   <= cd_p[g];
        sc_p[g+1]   <= sc_p[g];
      end
    end
  end

  // Multiply chain: K*Cd, *A, *s, *scale, then one per axis
  logic [63:0] speed;
  logic        live;
  assign speed = {30'd0, root_r[NSQ]};
  assign live  = gate_p[NSQ] && area_p[NSQ] != 64'd0 && speed != 64'd0;

  logic [63:0] ma [4];
  logic [63:0] mb [4];
  logic [63:0] mp [4];
  logic        ms [4];
  logic [63:0] opnd_r [4][3];   // operands for later stages: A, s, scale
  logic [32:0] mg_r   [4][3];
  logic [2:0]  ng_r   [4];
  logic        lv_r   [4];
  logic        sp_r   [4];

  // Each multiply output is registered once more before the next stage
  logic [63:0] mq_r [4];
  logic        sq_r [4];
  logic [63:0] oq_r [4][3];
  logic [32:0] gq_r [4][3];
  logic [2:0]  nq_r [4];
  logic        lq_r [4];

  // Stage operands ride alongside each multiply and its result register
  always_ff @(posedge clk) begin
    if (adv) begin
      opnd_r[0][0] <= area_p[NSQ];
      opnd_r[0][1] <= speed;
      opnd_r[0][2] <= {32'd0, sc_p[NSQ]};
      mg_r[0]      <= mag_p[NSQ];
      ng_r[0]      <= neg_p[NSQ];
      lv_r[0]      <= live;
      sp_r[0]      <= 1'b0;
      for (int k = 1; k < 4; k++) begin
        opnd_r[k] <= oq_r[k-1];
        mg_r[k]   <= gq_r[k-1];
        ng_r[k]   <= nq_r[k-1];
        lv_r[k]   <= lq_r[k-1];
        sp_r[k]   <= sq_r[k-1];
      end
    end
  end

  assign ma[0] = KQ;
  assign mb[0] = {32'd0, cd_p[NSQ]};
  for (genvar k = 1; k < 4; k++) begin : g_chain
    assign ma[k] = mq_r[k-1];
    assign mb[k] = oq_r[k-1][k-1];
  end

  for (genvar k = 0; k < 4; k++) begin : g_mul
    qdf_mul64 #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk(clk), .en(adv), .a(ma[k]), .b(mb[k]), .p(mp[k]), .sat(ms[k])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        mq_r[k] <= mp[k];
        sq_r[k] <= ms[k] | sp_r[k];
        oq_r[k] <= opnd_r[k];
        gq_r[k] <= mg_r[k];
        nq_r[k] <= ng_r[k];
        lq_r[k] <= lv_r[k];
      end
    end
  end

  // Per-axis force multiply
  logic [63:0] fp [3];
  logic        fs [3];
  for (genvar i = 0; i < 3; i++) begin : g_axis
    qdf_mul64 #(.FRAC_BITS(FRAC_BITS)) u_fmul (
      .clk(clk), .en(adv), .a({31'd0, gq_r[3][i]}), .b(mq_r[3]), .p(fp[i]), .sat(fs[i])
    );
  end

  logic [32:0] gf_r [3];
  logic [2:0]  nf_r;
  logic        lf_r, sf_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      gf_r <= gq_r[3];
      nf_r <= nq_r[3];
      lf_r <= lq_r[3];
      sf_r <= sq_r[3];
    end
  end

  // Clip, sign and flag
  logic [63:0] res [3];
  qdf_flags_t  fl;
  always_comb begin
    fl.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
      if (lf_r && gf_r[i] != 33'd0) begin
        if (fs[i] || fp[i][63]) begin
          res[i] = 64'h7FFF_FFFF_FFFF_FFFF;
          fl.sat = 1'b1;
        end else begin
          res[i] = fp[i];
        end
        if (nf_r[i]) res[i] = 64'(-res[i]);
      end
    end
    if (lf_r && sf_r) fl.sat = 1'b1;
    fl.zero = res[0] == 64'd0 && res[1] == 64'd0 && res[2] == 64'd0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata <= {6'd0, fl.sat, fl.zero, res[2], res[1], res[0]};
    end
  end
  assign out_tvalid = vld_r[DEPTH-1];

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("ready while stalled");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed in stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[192] |-> out_tdata[191:0] == 192'd0) else $error("zero flag");
`endif

endmodule
